// ===== hdl/pixel_clock_divider_search_unit_assert.svh =====
// Assertion macros used by the search unit control.
`ifndef PIXEL_CLOCK_DIVIDER_SEARCH_UNIT_ASSERT_SVH
`define PIXEL_CLOCK_DIVIDER_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define PCDS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcds assertion failed");

// Antecedent implies consequent in the next cycle.
`define PCDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcds assertion failed");

`else

`define PCDS_ASSERT_SAME(label, clk, rst, ante, cons)
`define PCDS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/pcds_pkg.sv =====
package pcds_pkg;

   localparam int MAX_DIVIDER = 255;
   localparam int RATE_WIDTH  = 32;
   localparam int DIV_WIDTH   = $clog2(MAX_DIVIDER + 1);
   localparam int CNT_WIDTH   = $clog2(RATE_WIDTH + 1);

   typedef logic [DIV_WIDTH-1:0]  div_type;
   typedef logic [RATE_WIDTH-1:0] rate_type;
   typedef logic [CNT_WIDTH-1:0]  cnt_type;

   localparam div_type MIN_PD_TFT   = div_type'(2);
   localparam div_type MIN_PD_OTHER = div_type'(3);
   localparam div_type FIRST_LD     = div_type'(1);
   localparam div_type LAST_DIVIDER = div_type'(MAX_DIVIDER);

   typedef struct packed {
      logic init;
      logic start_link;
      logic start_pixel;
      logic cap_link;
      logic cap_pixel;
      logic measure;
      logic eval;
      logic step_pd;
      logic step_ld;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic hit;
      logic below;
      logic first_below;
      logic pd_last;
      logic ld_last;
   } sts_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_LDIV  = 9'b000000010,
      S_LWAIT = 9'b000000100,
      S_PDIV  = 9'b000001000,
      S_PWAIT = 9'b000010000,
      S_DIST  = 9'b000100000,
      S_EVAL  = 9'b001000000,
      S_STEP  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

endpackage

// ===== hdl/pcds_divider.sv =====
module pcds_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pcds_pkg::rate_type  dividend,
   input  pcds_pkg::div_type   divisor,
   output logic                done,
   output pcds_pkg::rate_type  quotient
);
   import pcds_pkg::*;

   // Restoring division, one quotient bit per cycle. The remainder stays
   // below the divisor, so it fits the divisor width.
   logic     running_ff, running_in;
   logic     done_ff, done_in;
   cnt_type  cnt_ff, cnt_in;
   rate_type quo_ff, quo_in;
   div_type  rem_ff, rem_in;
   div_type  dvs_ff, dvs_in;

   logic [DIV_WIDTH:0] shifted;
   logic               ge;

   always_comb begin
      shifted    = {rem_ff, quo_ff[RATE_WIDTH-1]};
      ge         = shifted >= {1'b0, dvs_ff};
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = cnt_type'(RATE_WIDTH);
         quo_in     = dividend;
         rem_in     = '0;
         dvs_in     = divisor;
      end else if (running_ff) begin
         quo_in = {quo_ff[RATE_WIDTH-2:0], ge};
         rem_in = ge ? DIV_WIDTH'(shifted - {1'b0, dvs_ff}) : shifted[DIV_WIDTH-1:0];
         cnt_in = cnt_ff - cnt_type'(1);
         if (cnt_ff == cnt_type'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/pcds_datapath.sv =====
module pcds_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pcds_pkg::cmd_type   cmd,
   output pcds_pkg::sts_type   sts,
   input  logic                req_tft_panel,
   input  pcds_pkg::rate_type  req_requested_rate,
   input  pcds_pkg::rate_type  req_source_rate,
   output pcds_pkg::div_type   rsp_link_divider,
   output pcds_pkg::div_type   rsp_pixel_divider,
   output pcds_pkg::rate_type  rsp_link_rate,
   output pcds_pkg::rate_type  rsp_pixel_rate
);
   import pcds_pkg::*;

   logic     tft_ff, tft_in;
   rate_type req_ff, req_in;
   rate_type src_ff, src_in;
   div_type  ld_ff, ld_in;
   div_type  pd_ff, pd_in;
   rate_type lck_ff, lck_in;
   rate_type pck_ff, pck_in;
   rate_type dist_ff, dist_in;
   logic     eq_ff, eq_in;
   logic     below_ff, below_in;
   logic     first_below_ff, first_below_in;
   logic     have_ff, have_in;
   div_type  best_ld_ff, best_ld_in;
   div_type  best_pd_ff, best_pd_in;
   rate_type best_lck_ff, best_lck_in;
   rate_type best_pck_ff, best_pck_in;
   rate_type best_dist_ff, best_dist_in;

   div_type  min_pd;
   logic     take;
   logic     div_start;
   rate_type div_dividend;
   div_type  div_divisor;
   logic     div_done;
   rate_type div_quotient;

   assign min_pd       = tft_ff ? MIN_PD_TFT : MIN_PD_OTHER;
   assign div_start    = cmd.start_link | cmd.start_pixel;
   assign div_dividend = cmd.start_link ? src_ff : lck_ff;
   assign div_divisor  = cmd.start_link ? ld_ff : pd_ff;

   pcds_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // The first candidate is always taken; later ones need a strictly
   // smaller distance.
   assign take = !have_ff || (dist_ff < best_dist_ff);

   always_comb begin
      tft_in         = tft_ff;
      req_in         = req_ff;
      src_in         = src_ff;
      ld_in          = ld_ff;
      pd_in          = pd_ff;
      lck_in         = lck_ff;
      pck_in         = pck_ff;
      dist_in        = dist_ff;
      eq_in          = eq_ff;
      below_in       = below_ff;
      first_below_in = first_below_ff;
      have_in        = have_ff;
      best_ld_in     = best_ld_ff;
      best_pd_in     = best_pd_ff;
      best_lck_in    = best_lck_ff;
      best_pck_in    = best_pck_ff;
      best_dist_in   = best_dist_ff;
      if (cmd.init) begin
         tft_in  = req_tft_panel;
         req_in  = req_requested_rate;
         src_in  = req_source_rate;
         ld_in   = FIRST_LD;
         pd_in   = req_tft_panel ? MIN_PD_TFT : MIN_PD_OTHER;
         have_in = 1'b0;
      end
      if (cmd.cap_link) begin
         lck_in = div_quotient;
      end
      if (cmd.cap_pixel) begin
         pck_in = div_quotient;
      end
      if (cmd.measure) begin
         dist_in  = (pck_ff >= req_ff) ? (pck_ff - req_ff) : (req_ff - pck_ff);
         eq_in    = pck_ff == req_ff;
         below_in = pck_ff < req_ff;
         // The first pixel trial of a link divider is the link rate over
         // the minimum divider, which bounds the outer search.
         if (pd_ff == min_pd) begin
            first_below_in = pck_ff < req_ff;
         end
      end
      if (cmd.eval && take) begin
         have_in      = 1'b1;
         best_ld_in   = ld_ff;
         best_pd_in   = pd_ff;
         best_lck_in  = lck_ff;
         best_pck_in  = pck_ff;
         best_dist_in = dist_ff;
      end
      if (cmd.step_pd) begin
         pd_in = pd_ff + div_type'(1);
      end
      if (cmd.step_ld) begin
         ld_in = ld_ff + div_type'(1);
         pd_in = min_pd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      tft_ff         <= tft_in;
      req_ff         <= req_in;
      src_ff         <= src_in;
      ld_ff          <= ld_in;
      pd_ff          <= pd_in;
      lck_ff         <= lck_in;
      pck_ff         <= pck_in;
      dist_ff        <= dist_in;
      eq_ff          <= eq_in;
      below_ff       <= below_in;
      first_below_ff <= first_below_in;
      best_ld_ff     <= best_ld_in;
      best_pd_ff     <= best_pd_in;
      best_lck_ff    <= best_lck_in;
      best_pck_ff    <= best_pck_in;
      best_dist_ff   <= best_dist_in;
   end

   always_comb begin
      sts.div_done    = div_done;
      sts.hit         = take && eq_ff;
      sts.below       = below_ff;
      sts.first_below = first_below_ff;
      sts.pd_last     = pd_ff == LAST_DIVIDER;
      sts.ld_last     = ld_ff == LAST_DIVIDER;
   end

   assign rsp_link_divider  = best_ld_ff;
   assign rsp_pixel_divider = best_pd_ff;
   assign rsp_link_rate     = best_lck_ff;
   assign rsp_pixel_rate    = best_pck_ff;

endmodule

// ===== hdl/pcds_control.sv =====
`include "pixel_clock_divider_search_unit_assert.svh"

module pcds_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   output pcds_pkg::cmd_type  cmd,
   input  pcds_pkg::sts_type  sts
);
   import pcds_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.init = 1'b1;
               state_in = S_LDIV;
            end
         end
         S_LDIV: begin
            cmd.start_link = 1'b1;
            state_in       = S_LWAIT;
         end
         S_LWAIT: begin
            if (sts.div_done) begin
               cmd.cap_link = 1'b1;
               state_in     = S_PDIV;
            end
         end
         S_PDIV: begin
            cmd.start_pixel = 1'b1;
            state_in        = S_PWAIT;
         end
         S_PWAIT: begin
            if (sts.div_done) begin
               cmd.cap_pixel = 1'b1;
               state_in      = S_DIST;
            end
         end
         S_DIST: begin
            cmd.measure = 1'b1;
            state_in    = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_STEP;
            if (sts.hit) begin
               state_in = S_DONE;
            end
         end
         S_STEP: begin
            // The inner loop ends below the request or at the last divider;
            // then the outer bound decides whether another link divider runs.
            if (sts.below || sts.pd_last) begin
               if (sts.first_below || sts.ld_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.step_ld = 1'b1;
                  state_in    = S_LDIV;
               end
            end else begin
               cmd.step_pd = 1'b1;
               state_in    = S_PDIV;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_DONE;

   `PCDS_ASSERT_NEXT(a_done_returns_idle, clock, reset, state_ff == S_DONE, state_ff == S_IDLE)
   `PCDS_ASSERT_NEXT(a_start_begins_search, clock, reset, !busy && start, state_ff == S_LDIV)
   `PCDS_ASSERT_NEXT(a_hit_ends_search, clock, reset, state_ff == S_EVAL && sts.hit, rsp_valid)
   `PCDS_ASSERT_SAME(a_done_only_in_wait, clock, reset, sts.div_done,
      state_ff == S_LWAIT || state_ff == S_PWAIT)

endmodule

// ===== hdl/pixel_clock_divider_search_unit.sv =====
// Each link divider tried costs one 32-step division; each pixel divider tried costs a
// division, distance, compare and step, with the step left out for the trial that
// matches exactly; a result state ends the search.
// One bit-serial divider is shared by the link and pixel divisions; one item is searched at a time.
// The next beat is accepted in the cycle after the result strobe, once the control is idle.
// Reset is synchronous and returns the search to idle; the receiver cannot stall.
module pixel_clock_divider_search_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_tft_panel,
   input  pcds_pkg::rate_type  req_requested_rate,
   input  pcds_pkg::rate_type  req_source_rate,
   output logic                rsp_valid,
   output pcds_pkg::div_type   rsp_link_divider,
   output pcds_pkg::div_type   rsp_pixel_divider,
   output pcds_pkg::rate_type  rsp_link_rate,
   output pcds_pkg::rate_type  rsp_pixel_rate
);
   import pcds_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pcds_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   pcds_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_tft_panel      (req_tft_panel),
      .req_requested_rate (req_requested_rate),
      .req_source_rate    (req_source_rate),
      .rsp_link_divider   (rsp_link_divider),
      .rsp_pixel_divider  (rsp_pixel_divider),
      .rsp_link_rate      (rsp_link_rate),
      .rsp_pixel_rate     (rsp_pixel_rate)
   );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pcds_pkg::*;

   localparam int   CYCLE_LIMIT  = 5_000_000;
   localparam int   RANDOM_ITEMS = 100;
   localparam int   TAIL_CYCLES  = 40;
   localparam int   MAX_GAP      = 11;
   localparam logic PANEL_TFT    = 1'b1;
   localparam logic PANEL_OTHER  = 1'b0;
   localparam logic TYPED        = 1'b1;
   localparam logic PREDICTED    = 1'b0;

   typedef struct packed {
      div_type  link_div;
      div_type  pixel_div;
      rate_type link_rate;
      rate_type pixel_rate;
   } divider_choice_type;

   typedef struct packed {
      logic               tft;
      rate_type           want_rate;
      rate_type           src_rate;
      logic               typed;
      divider_choice_type choice;
   } stim_row_type;

   localparam divider_choice_type NO_RESULT = '0;

   // Rows marked TYPED carry a result that follows directly from the search rules:
   // the first candidate wins and either hits exactly or already lies below the request.
   localparam stim_row_type DIRECTED_ROWS [20] = '{
      '{PANEL_TFT,   32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED,
        '{8'd1, 8'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF}},
      '{PANEL_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED,
        '{8'd1, 8'd3, 32'hFFFF_FFFF, 32'h5555_5555}},
      '{PANEL_TFT,   32'd0,         32'd0,         TYPED, '{8'd1, 8'd2, 32'd0, 32'd0}},
      '{PANEL_OTHER, 32'd0,         32'd0,         TYPED, '{8'd1, 8'd3, 32'd0, 32'd0}},
      '{PANEL_TFT,   32'hFFFF_FFFF, 32'd0,         TYPED, '{8'd1, 8'd2, 32'd0, 32'd0}},
      '{PANEL_OTHER, 32'd1,         32'd0,         TYPED, '{8'd1, 8'd3, 32'd0, 32'd0}},
      '{PANEL_TFT,   32'd500,       32'd1000,      TYPED,
        '{8'd1, 8'd2, 32'd1000, 32'd500}},
      '{PANEL_OTHER, 32'd300,       32'd900,       TYPED,
        '{8'd1, 8'd3, 32'd900, 32'd300}},
      '{PANEL_TFT,   32'h7FFF_FFFF, 32'hFFFF_FFFF, TYPED,
        '{8'd1, 8'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF}},
      '{PANEL_TFT,   32'h8000_0000, 32'hFFFF_FFFF, TYPED,
        '{8'd1, 8'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF}},
      '{PANEL_OTHER, 32'hFFFF_FFFF, 32'd1,         TYPED, '{8'd1, 8'd3, 32'd1, 32'd0}},
      '{PANEL_TFT,   32'h5555_5555, 32'hAAAA_AAAA, TYPED,
        '{8'd1, 8'd2, 32'hAAAA_AAAA, 32'h5555_5555}},
      '{PANEL_TFT,   32'd0,         32'd100,       PREDICTED, NO_RESULT},
      '{PANEL_OTHER, 32'd0,         32'd600,       PREDICTED, NO_RESULT},
      '{PANEL_TFT,   32'd1000,      32'd300000,    PREDICTED, NO_RESULT},
      '{PANEL_OTHER, 32'd12345,     32'd1000000,   PREDICTED, NO_RESULT},
      '{PANEL_OTHER, 32'd7,         32'd50,        PREDICTED, NO_RESULT},
      '{PANEL_TFT,   32'd13,        32'd200,       PREDICTED, NO_RESULT},
      '{PANEL_TFT,   32'd3,         32'd20,        PREDICTED, NO_RESULT},
      '{PANEL_OTHER, 32'h0100_0000, 32'hFFFF_FFFF, PREDICTED, NO_RESULT}
   };

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   logic     req_tft_panel = 1'b0;
   rate_type req_requested_rate = '0;
   rate_type req_source_rate = '0;
   logic     rsp_valid;
   div_type  rsp_link_divider;
   div_type  rsp_pixel_divider;
   rate_type rsp_link_rate;
   rate_type rsp_pixel_rate;

   divider_choice_type pending_choices [$];
   divider_choice_type oldest_choice;
   int mismatch_count  = 0;
   int searches_sent   = 0;
   int tft_searches    = 0;
   int results_checked = 0;
   int cycle_count     = 0;

   pixel_clock_divider_search_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_tft_panel      (req_tft_panel),
      .req_requested_rate (req_requested_rate),
      .req_source_rate    (req_source_rate),
      .rsp_valid          (rsp_valid),
      .rsp_link_divider   (rsp_link_divider),
      .rsp_pixel_divider  (rsp_pixel_divider),
      .rsp_link_rate      (rsp_link_rate),
      .rsp_pixel_rate     (rsp_pixel_rate)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Walks the link and pixel divider pairs and keeps the one closest to the request.
   function automatic divider_choice_type search_dividers(input logic tft,
                                                          input rate_type want_rate,
                                                          input rate_type src_rate);
      logic [63:0] min_pd, want_hz, link_hz, pix_hz, gap_hz, best_gap;
      int ld, pd, best_ld, best_pd;
      bit have_best, hit;
      divider_choice_type choice;
      min_pd    = tft ? 64'(MIN_PD_TFT) : 64'(MIN_PD_OTHER);
      want_hz   = 64'(want_rate);
      have_best = 1'b0;
      hit       = 1'b0;
      best_gap  = '0;
      best_ld   = int'(FIRST_LD);
      best_pd   = int'(min_pd);
      for (ld = 1; ld <= MAX_DIVIDER; ld++) begin
         link_hz = 64'(src_rate) / 64'(ld);
         for (pd = int'(min_pd); pd <= MAX_DIVIDER; pd++) begin
            pix_hz = link_hz / 64'(pd);
            gap_hz = (pix_hz >= want_hz) ? pix_hz - want_hz : want_hz - pix_hz;
            if (!have_best || gap_hz < best_gap) begin
               have_best = 1'b1;
               best_gap  = gap_hz;
               best_ld   = ld;
               best_pd   = pd;
               if (pix_hz == want_hz) begin
                  hit = 1'b1;
                  break;
               end
            end
            if (pix_hz < want_hz) break;
         end
         if (hit) break;
         if (link_hz / min_pd < want_hz) break;
      end
      choice.link_div   = div_type'(best_ld);
      choice.pixel_div  = div_type'(best_pd);
      choice.link_rate  = rate_type'(64'(src_rate) / 64'(best_ld));
      choice.pixel_rate = rate_type'(64'(choice.link_rate) / 64'(best_pd));
      return choice;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%08h, want 0x%08h", field, got, want));
   endtask

   // Start stays high across back-to-back beats; it drops for a drawn gap and in drain_results.
   task automatic send_search(input logic tft, input rate_type want_rate,
                              input rate_type src_rate, input logic typed,
                              input divider_choice_type typed_choice);
      int gap;
      gap = $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_tft_panel      <= tft;
      req_requested_rate <= want_rate;
      req_source_rate    <= src_rate;
      do @(posedge clock); while (busy);
      pending_choices.push_back(typed ? typed_choice
                                      : search_dividers(tft, want_rate, src_rate));
      searches_sent++;
      if (tft) tft_searches++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_choices.size() == 0) begin
            report_mismatch("result strobe with no search outstanding");
         end else begin
            oldest_choice = pending_choices.pop_front();
            check_field("link_divider", 32'(rsp_link_divider), 32'(oldest_choice.link_div));
            check_field("pixel_divider", 32'(rsp_pixel_divider),
                        32'(oldest_choice.pixel_div));
            check_field("link_rate", rsp_link_rate, oldest_choice.link_rate);
            check_field("pixel_rate", rsp_pixel_rate, oldest_choice.pixel_rate);
            results_checked++;
         end
      end
   end

   initial begin
      logic     tft;
      rate_type want_rate, src_rate;
      logic [63:0] src_wide;
      int ratio, n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_search(DIRECTED_ROWS[i].tft, DIRECTED_ROWS[i].want_rate,
                     DIRECTED_ROWS[i].src_rate, DIRECTED_ROWS[i].typed,
                     DIRECTED_ROWS[i].choice);
      drain_results();

      // Source over request is kept small to keep each search short.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_results();
         tft = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 85) begin
            want_rate = $urandom >> $urandom_range(0, 31);
            ratio     = $urandom_range(1, 40);
            src_wide  = 64'(want_rate) * 64'(ratio);
            if ($urandom_range(0, 3) != 0)
               src_wide += 64'($urandom_range(want_rate, 0));
            if (src_wide > 64'hFFFF_FFFF)
               src_rate = $urandom_range(32'hFFFF_FFFF, want_rate);
            else
               src_rate = rate_type'(src_wide);
         end else begin
            want_rate = $urandom;
            src_rate  = $urandom_range(want_rate, 0);
         end
         send_search(tft, want_rate, src_rate, PREDICTED, NO_RESULT);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d divider searches, %0d of them with the TFT minimum divider.",
               searches_sent, tft_searches);
      $display("Compared %0d results field by field, %0d mismatches.",
               results_checked, mismatch_count);
      if (mismatch_count == 0 && pending_choices.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
